// ===== rtl/radix_ascii_to_integer_parser_assert.svh =====
// ----------------------------------------------------------------------------
// radix_ascii_to_integer_parser_assert.svh
// assertion macros for the radix ascii-to-integer parser
// ----------------------------------------------------------------------------
`ifndef RADIX_ASCII_TO_INTEGER_PARSER_ASSERT_SVH
`define RADIX_ASCII_TO_INTEGER_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define RATI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RATI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rati_pkg.sv =====
// ----------------------------------------------------------------------------
// rati_pkg
// types, character codes and digit decode for the radix ascii parser
// ----------------------------------------------------------------------------
package rati_pkg;

  localparam int CharWidth  = 8;
  localparam int RadixWidth = 6;
  localparam int ValueWidth = 64;
  localparam int OffsWidth  = 16;
  localparam int DigitWidth = 7;

  // character codes
  localparam logic [CharWidth-1:0] CH_SPACE = 8'h20;
  localparam logic [CharWidth-1:0] CH_TAB   = 8'h09;
  localparam logic [CharWidth-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharWidth-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharWidth-1:0] CH_0     = 8'h30;
  localparam logic [CharWidth-1:0] CH_9     = 8'h39;
  localparam logic [CharWidth-1:0] CH_LA    = 8'h61;
  localparam logic [CharWidth-1:0] CH_LZ    = 8'h7A;
  localparam logic [CharWidth-1:0] CH_UA    = 8'h41;
  localparam logic [CharWidth-1:0] CH_UZ    = 8'h5A;

  // radix limits
  localparam logic [RadixWidth-1:0] RADIX_DEFAULT = 6'd10;
  localparam logic [RadixWidth-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RadixWidth-1:0] RADIX_MAX     = 6'd36;

  // digit value for a non-alphanumeric character, and the digit value of the letter a or A
  localparam logic [DigitWidth-1:0] DIGIT_NONE   = 7'd99;
  localparam logic [DigitWidth-1:0] DIGIT_LETTER = 7'd10;

  // parse phase, one-hot
  typedef enum logic [2:0] {
    PH_BLANK  = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  // digit value of a character, DIGIT_NONE if not alphanumeric
  function automatic logic [DigitWidth-1:0] digit_of(input logic [CharWidth-1:0] c);
    logic [DigitWidth-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) begin
      d = DigitWidth'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DigitWidth'(c - CH_LA) + DIGIT_LETTER;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DigitWidth'(c - CH_UA) + DIGIT_LETTER;
    end
    return d;
  endfunction

endpackage

// ===== rtl/rati_in_if.sv =====
// ----------------------------------------------------------------------------
// rati_in_if
// character channel: valid/ready handshake with one character per item
// ----------------------------------------------------------------------------
interface rati_in_if
  import rati_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] char_code;
  logic                 start_new;

  modport source (output valid, output char_code, output start_new, input ready);
  modport sink   (input valid, input char_code, input start_new, output ready);
endinterface

// ===== rtl/rati_out_if.sv =====
// ----------------------------------------------------------------------------
// rati_out_if
// result channel: valid/ready handshake with the parse state per item
// ----------------------------------------------------------------------------
interface rati_out_if
  import rati_pkg::*;
;
  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] value;
  logic [OffsWidth-1:0]         end_offset;
  logic                         digit_seen;
  logic                         overflow;
  logic                         done_res;

  modport source (output valid, output value, output end_offset, output digit_seen,
                  output overflow, output done_res, input ready);
  modport sink   (input valid, input value, input end_offset, input digit_seen,
                  input overflow, input done_res, output ready);
endinterface

// ===== rtl/radix_ascii_to_integer_parser.sv =====
// throughput: one character per cycle while out_ch.ready does not hold the result
//   register, set by the single multiply-add of the accumulator by the radix
//   between the input register and the result register
// reset (rst, synchronous): radix returns to ten, parse state clears,
//   both pipeline registers empty
// ----------------------------------------------------------------------------
// radix_ascii_to_integer_parser
// strtol-style signed integer parser, one character per item, radix 2..36
// ----------------------------------------------------------------------------
module radix_ascii_to_integer_parser
  import rati_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RadixWidth-1:0] cfg_wdata,
  rati_in_if.sink               in_ch,
  rati_out_if.source            out_ch
);

`include "radix_ascii_to_integer_parser_assert.svh"

  localparam int MacWidth = ValueWidth + RadixWidth;

  // configuration
  logic [RadixWidth-1:0] radix;

  // input register
  logic                 s1_valid;
  logic [CharWidth-1:0] s1_char;
  logic                 s1_start;

  // parse state
  phase_t                 phase, phase_next;
  logic                   negative, negative_next;
  logic [ValueWidth-1:0]  accumulator, accumulator_next;
  logic [COUNT_WIDTH-1:0] consumed, consumed_next;
  logic                   any_digit, any_digit_next;
  logic                   wrapped, wrapped_next;

  // result register
  logic                         out_valid;
  logic signed [ValueWidth-1:0] res_value;
  logic [OffsWidth-1:0]         res_offset;
  logic                         res_digit;
  logic                         res_ovf;
  logic                         res_done;

  // datapath helpers
  phase_t                 cur_phase;
  logic                   cur_neg;
  logic [ValueWidth-1:0]  cur_acc;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic                   cur_any;
  logic                   cur_wrap;
  logic [RadixWidth-1:0]  r_eff;
  logic                   radix_ok;
  logic [DigitWidth-1:0]  digit;
  logic                   digit_ok;
  logic [MacWidth-1:0]    mac;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH+OffsWidth-1:0] cnt_wide;
  logic                   s1_advance;
  logic                   item_in;

  // handshake
  assign s1_advance   = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || s1_advance;
  assign item_in      = in_ch.valid && in_ch.ready;

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_DEFAULT;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in) begin
      s1_char  <= in_ch.char_code;
      s1_start <= in_ch.start_new;
    end
  end

  // state seen by this item, cleared on start_new
  always_comb begin
    cur_phase = s1_start ? PH_BLANK : phase;
    cur_neg   = s1_start ? 1'b0 : negative;
    cur_acc   = s1_start ? '0 : accumulator;
    cur_cnt   = s1_start ? '0 : consumed;
    cur_any   = s1_start ? 1'b0 : any_digit;
    cur_wrap  = s1_start ? 1'b0 : wrapped;
  end

  // digit decode and multiply-add
  assign r_eff    = (radix == '0) ? RADIX_DEFAULT : radix;
  assign radix_ok = (r_eff >= RADIX_MIN) && (r_eff <= RADIX_MAX);
  assign digit    = digit_of(s1_char);
  assign digit_ok = radix_ok && (digit < DigitWidth'(r_eff));
  assign mac      = MacWidth'(cur_acc) * MacWidth'(r_eff) + MacWidth'(digit);
  assign cnt_inc  = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;

  // parse step
  always_comb begin
    phase_next       = cur_phase;
    negative_next    = cur_neg;
    accumulator_next = cur_acc;
    consumed_next    = cur_cnt;
    any_digit_next   = cur_any;
    wrapped_next     = cur_wrap;
    unique case (cur_phase)
      PH_BLANK: begin
        if (s1_char == CH_SPACE || s1_char == CH_TAB) begin
          consumed_next = cnt_inc;
        end else if (s1_char == CH_MINUS || s1_char == CH_PLUS) begin
          negative_next = (s1_char == CH_MINUS);
          consumed_next = cnt_inc;
          phase_next    = PH_DIGITS;
        end else if (digit_ok) begin
          accumulator_next = mac[ValueWidth-1:0];
          wrapped_next     = cur_wrap || (|mac[MacWidth-1:ValueWidth]);
          any_digit_next   = 1'b1;
          consumed_next    = cnt_inc;
          phase_next       = PH_DIGITS;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (digit_ok) begin
          accumulator_next = mac[ValueWidth-1:0];
          wrapped_next     = cur_wrap || (|mac[MacWidth-1:ValueWidth]);
          any_digit_next   = 1'b1;
          consumed_next    = cnt_inc;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_BLANK;
      negative    <= 1'b0;
      accumulator <= '0;
      consumed    <= '0;
      any_digit   <= 1'b0;
      wrapped     <= 1'b0;
    end else if (s1_advance) begin
      phase       <= phase_next;
      negative    <= negative_next;
      accumulator <= accumulator_next;
      consumed    <= consumed_next;
      any_digit   <= any_digit_next;
      wrapped     <= wrapped_next;
    end
  end

  // low bits of the count, zero-extended for narrow counters
  assign cnt_wide = {{OffsWidth{1'b0}}, consumed_next};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_value  <= negative_next ? ValueWidth'(-accumulator_next) : accumulator_next;
      res_offset <= any_digit_next ? cnt_wide[OffsWidth-1:0] : '0;
      res_digit  <= any_digit_next;
      res_ovf    <= wrapped_next;
      res_done   <= (phase_next == PH_DONE);
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.value      = res_value;
  assign out_ch.end_offset = res_offset;
  assign out_ch.digit_seen = res_digit;
  assign out_ch.overflow   = res_ovf;
  assign out_ch.done_res   = res_done;

  // checks
  `RATI_ASSERT_NEXT(a_done_sticky,
    phase == PH_DONE && !(s1_advance && s1_start), phase == PH_DONE,
    "parse left done without start_new")
  `RATI_ASSERT_NOW(a_offset_zero, out_valid && !res_digit, res_offset == '0,
    "end offset nonzero without a digit")
  `RATI_ASSERT_NEXT(a_no_bubble, s1_valid && !out_valid, out_valid,
    "held item did not move to result register")

endmodule
